[design/lbm_pkg.sv]
// Shared types, constants and helper functions of the D2Q9 BGK collide-and-stream core.
`default_nettype none

package lbm_pkg;

    localparam int COORD_W   = 6;
    localparam int GRID_SIZE = 2 ** COORD_W;
    localparam int VAL_W     = 24;
    localparam int FRAC_W    = 20;
    localparam int OMEGA_W   = 22;
    localparam int NUM_DIR   = 9;
    localparam int DIR_W     = 4;
    localparam int SUM_W     = 28;
    localparam int MOM_W     = 27;
    localparam int ABS_W     = 27;
    localparam int QUOT_W    = 24;
    localparam int DIV_STEPS = 3;
    localparam int DIV_CYCLES = QUOT_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CYCLES);
    localparam int USQ_W     = 28;
    localparam int LANE_DEPTH = 8;

    localparam logic [OMEGA_W-1:0] OMEGA_RESET = 22'd1747627;
    localparam logic [DIR_W-1:0]   DIR_LAST    = DIR_W'(NUM_DIR - 1);
    localparam logic [DIR_W-1:0]   DIR_REST    = '0;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [1:0]       t_step;

    localparam t_val VAL_MAX = 24'sh7FFFFF;
    localparam t_val VAL_MIN = 24'sh800000;

    localparam t_step DIR_CX [NUM_DIR] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                           2'sd1, -2'sd1, -2'sd1, 2'sd1};
    localparam t_step DIR_CY [NUM_DIR] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                           2'sd1, 2'sd1, -2'sd1, -2'sd1};
    // Weights 4/9, 1/9 and 1/36 become a shift followed by a divide by nine.
    localparam logic [4:0] W_SHIFT [NUM_DIR] = '{5'd18, 5'd20, 5'd20, 5'd20, 5'd20,
                                                 5'd22, 5'd22, 5'd22, 5'd22};

    localparam logic [24:0] RECIP9 = 25'd29826161;

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        t_val               dist_rest;
        t_val               dist_east;
        t_val               dist_north;
        t_val               dist_west;
        t_val               dist_south;
        t_val               dist_northeast;
        t_val               dist_northwest;
        t_val               dist_southwest;
        t_val               dist_southeast;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [DIR_W-1:0]   direction;
        t_val               post_value;
        logic               zero_density;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               z;
    } t_meta;

    typedef struct packed {
        logic [20:0] q;
        logic [3:0]  r;
    } t_div9;

    // Divides a value below 2^24 by nine with a reciprocal and one correction.
    function automatic t_div9 div9(input logic [23:0] x);
        logic [48:0] prod;
        logic [20:0] q0;
        logic [24:0] r0;
        t_div9       res;
        prod = x * RECIP9;
        q0   = prod[48:28];
        r0   = 25'(x) - 25'(q0) * 25'd9;
        if (r0 >= 25'd9) begin
            res.q = q0 + 21'd1;
            res.r = 4'(r0 - 25'd9);
        end else begin
            res.q = q0;
            res.r = r0[3:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[design/lbm_div.sv]
// Iterative signed divider forming one saturated Q4.20 velocity component.
`default_nettype none

module lbm_div import lbm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_start,
    input  logic                    i_step,
    input  logic signed [MOM_W-1:0] i_num,
    input  logic signed [SUM_W-1:0] i_den,
    output t_val                    o_quot
);

    localparam int PRE_W = QUOT_W - FRAC_W;

    logic [ABS_W-1:0]  r_rem;
    logic [ABS_W-1:0]  r_ad;
    logic [QUOT_W-1:0] r_bits;
    logic [QUOT_W-1:0] r_q;
    logic              r_neg;
    logic              r_ovf;
    logic              r_zero;

    logic [ABS_W-1:0]  an;
    logic [ABS_W-1:0]  ad;
    logic [ABS_W-1:0]  n_rem;
    logic [QUOT_W-1:0] n_bits;
    logic [QUOT_W-1:0] n_q;

    assign an = ABS_W'(i_num[MOM_W-1] ? -i_num : i_num);
    assign ad = ABS_W'(i_den[SUM_W-1] ? -i_den : i_den);

    always_comb begin
        logic [ABS_W:0] trial;
        n_rem  = r_rem;
        n_bits = r_bits;
        n_q    = r_q;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial  = {n_rem, n_bits[QUOT_W-1]};
            n_bits = {n_bits[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, r_ad}) begin
                n_rem = ABS_W'(trial - {1'b0, r_ad});
                n_q   = {n_q[QUOT_W-2:0], 1'b1};
            end else begin
                n_rem = trial[ABS_W-1:0];
                n_q   = {n_q[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= ABS_W'(an >> PRE_W);
            r_bits <= QUOT_W'({an, FRAC_W'(0)});
            r_q    <= '0;
            r_ad   <= ad;
            r_neg  <= i_num[MOM_W-1] ^ i_den[SUM_W-1];
            r_ovf  <= ({PRE_W'(0), an} >= {ad, PRE_W'(0)});
            r_zero <= (i_den == '0);
        end else if (i_step) begin
            r_rem  <= n_rem;
            r_bits <= n_bits;
            r_q    <= n_q;
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_ovf) begin
            o_quot = r_neg ? VAL_MIN : VAL_MAX;
        end else if (!r_neg) begin
            o_quot = r_q[QUOT_W-1] ? VAL_MAX : t_val'(r_q);
        end else if (r_q[QUOT_W-1] && (r_q[QUOT_W-2:0] != '0)) begin
            o_quot = VAL_MIN;
        end else begin
            o_quot = t_val'(-r_q);
        end
    end

endmodule

`default_nettype wire

[design/lbm_lane.sv]
// One direction lane: equilibrium, relaxation and saturation in an eight-stage pipeline.
`default_nettype none

module lbm_lane import lbm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [DIR_W-1:0]        i_dir,
    input  t_val                    i_ux,
    input  t_val                    i_uy,
    input  logic [USQ_W-1:0]        i_usq3,
    input  logic signed [SUM_W-1:0] i_rho,
    input  t_val                    i_f,
    input  logic [OMEGA_W-1:0]      i_omega,
    output t_val                    o_post
);

    localparam logic signed [33:0] POLY_ONE = 34'sd1048576;
    localparam logic signed [33:0] POLY_HI  = 34'sd2147483648;
    localparam logic signed [33:0] POLY_LO  = -34'sd2147483648;
    localparam logic [59:0]        FEQ_SAT  = 60'd309237645321;
    localparam logic [35:0]        FEQ_MAX  = 36'd34359738368;

    logic signed [26:0]      r1_cu;
    logic [USQ_W-1:0]        r1_usq3;
    logic signed [SUM_W-1:0] r1_rho;
    t_val                    r1_f;
    logic [51:0]             r2_cc;
    logic signed [26:0]      r2_cu;
    logic [USQ_W-1:0]        r2_usq3;
    logic signed [SUM_W-1:0] r2_rho;
    t_val                    r2_f;
    logic signed [32:0]      r3_poly;
    logic signed [SUM_W-1:0] r3_rho;
    t_val                    r3_f;
    logic signed [60:0]      r4_p;
    t_val                    r4_f;
    logic [15:0]             r5_a;
    logic [3:0]              r5_b;
    logic [19:0]             r5_vl;
    logic                    r5_neg;
    logic                    r5_sat;
    t_val                    r5_f;
    logic signed [36:0]      r6_feq;
    t_val                    r6_f;
    logic [40:0]             r7_lo;
    logic signed [41:0]      r7_hi;
    t_val                    r7_f;
    t_val                    r8_post;

    logic signed [24:0] tx, ty;
    logic signed [25:0] s;
    logic signed [26:0] cu;
    logic signed [53:0] cc;
    logic signed [33:0] pl;
    logic signed [33:0] plc;
    logic signed [60:0] p;
    logic [59:0]        m;
    logic [59:0]        v0;
    t_div9              d1, d2;
    logic [35:0]        q;
    logic signed [37:0] diff;
    logic [40:0]        lo;
    logic signed [41:0] hi;
    logic signed [60:0] prod;
    logic signed [60:0] adj;
    logic signed [40:0] t;
    logic signed [41:0] post;

    always_comb begin
        tx = (DIR_CX[i_dir] == 2'sd1) ? 25'(i_ux) :
             (DIR_CX[i_dir] == -2'sd1) ? -(25'(i_ux)) : 25'sd0;
        ty = (DIR_CY[i_dir] == 2'sd1) ? 25'(i_uy) :
             (DIR_CY[i_dir] == -2'sd1) ? -(25'(i_uy)) : 25'sd0;
        s  = 26'(tx) + 26'(ty);
        cu = s * 27'sd3;
        cc = r1_cu * r1_cu;
        pl = POLY_ONE + 34'(r2_cu) + $signed({3'b0, r2_cc[51:21]})
             - $signed({6'b0, r2_usq3});
        if (pl > POLY_HI) begin
            plc = POLY_HI;
        end else if (pl < POLY_LO) begin
            plc = POLY_LO;
        end else begin
            plc = pl;
        end
        p  = r3_rho * r3_poly;
        m  = 60'(r4_p[60] ? -r4_p : r4_p);
        v0 = m >> W_SHIFT[i_dir];
        d1 = div9({5'b0, v0[38:20]});
        d2 = div9({r5_b, r5_vl});
        q  = r5_sat ? FEQ_MAX : {r5_a, d2.q[19:0]};
        diff = 38'(r6_f) - 38'(r6_feq);
        lo   = diff[18:0] * i_omega;
        hi   = $signed(diff[37:19]) * $signed({1'b0, i_omega});
        prod = (61'(r7_hi) <<< 19) + $signed({20'b0, r7_lo});
        adj  = prod[60] ? prod + 61'sd1048575 : prod;
        t    = adj[60:20];
        post = 42'(r7_f) - 42'(t);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cu   <= cu;
            r1_usq3 <= i_usq3;
            r1_rho  <= i_rho;
            r1_f    <= i_f;
            r2_cc   <= cc[51:0];
            r2_cu   <= r1_cu;
            r2_usq3 <= r1_usq3;
            r2_rho  <= r1_rho;
            r2_f    <= r1_f;
            r3_poly <= 33'(plc);
            r3_rho  <= r2_rho;
            r3_f    <= r2_f;
            r4_p    <= p;
            r4_f    <= r3_f;
            r5_a    <= d1.q[15:0];
            r5_b    <= d1.r;
            r5_vl   <= v0[19:0];
            r5_neg  <= r4_p[60];
            r5_sat  <= (v0 >= FEQ_SAT);
            r5_f    <= r4_f;
            r6_feq  <= r5_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
            r6_f    <= r5_f;
            r7_lo   <= lo;
            r7_hi   <= hi;
            r7_f    <= r6_f;
            if (post > 42'(VAL_MAX)) begin
                r8_post <= VAL_MAX;
            end else if (post < 42'(VAL_MIN)) begin
                r8_post <= VAL_MIN;
            end else begin
                r8_post <= t_val'(post);
            end
        end
    end

    assign o_post = r8_post;

endmodule

`default_nettype wire

[design/lbm_ser.sv]
// Merging stage: holds a cell's nine lane results; sends a word a cycle unless stalled.
`default_nettype none

module lbm_ser import lbm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_val      i_post [NUM_DIR],
    input  t_meta     i_meta,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_word o_word,
    output logic      o_ready
);

    t_val             r_post [NUM_DIR];
    t_meta            r_meta;
    logic [DIR_W-1:0] r_idx;
    logic             r_busy;

    assign o_ready = !r_busy || (r_idx == DIR_LAST && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= DIR_REST;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= DIR_REST;
        end else if (r_busy && !i_stall) begin
            if (r_idx == DIR_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_post <= i_post;
            r_meta <= i_meta;
        end
    end

    assign o_valid             = r_busy;
    assign o_word.dest_x       = r_meta.x + COORD_W'(DIR_CX[r_idx]);
    assign o_word.dest_y       = r_meta.y + COORD_W'(DIR_CY[r_idx]);
    assign o_word.direction    = r_idx;
    assign o_word.post_value   = r_post[r_idx];
    assign o_word.zero_density = r_meta.z;
    assign o_word.last         = (r_idx == DIR_LAST);

endmodule

`default_nettype wire

[design/d2q9_bgk_collide_stream_core.sv]
// Top level of the D2Q9 BGK collide-and-stream core: input slot, dividers, lanes and merge.
//
//   channel | direction | signals                                  | word
//   input   | in        | i_in_valid, o_in_stall, i_in_word        | one cell
//   output  | out       | o_out_valid, i_out_stall, o_out_word     | one direction of a cell
//   config  | in        | i_cfg_we, i_cfg_wdata                    | inverse relaxation
//
// Cell throughput is set by the two velocity dividers, which retire three quotient bits a cycle,
// and matches the nine output words per cell.
// Reset is synchronous and active low; it clears control state and restores the default omega.
// An output stall freezes the lane pipeline once a finished cell waits; the input slot then
// fills and raises o_in_stall.
`default_nettype none

module d2q9_bgk_collide_stream_core import lbm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_word           i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_word          o_out_word,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [OMEGA_W-1:0] i_cfg_wdata
);

    localparam int STAGES = 3 + LANE_DEPTH;

    logic [OMEGA_W-1:0]      r_omega;

    logic                    r_s_valid;
    t_val                    r_s_f [NUM_DIR];
    logic [COORD_W-1:0]      r_s_x, r_s_y;
    logic signed [SUM_W-1:0] r_s_rho;
    logic signed [MOM_W-1:0] r_s_mx, r_s_my;

    logic                    r_div_busy;
    logic                    r_div_done;
    logic [DIV_CNT_W-1:0]    r_div_cnt;
    t_val                    r_d_f [NUM_DIR];
    logic signed [SUM_W-1:0] r_d_rho;
    t_meta                   r_d_meta;

    t_val                    r_a_ux, r_a_uy;
    t_val                    r_a_f [NUM_DIR];
    logic signed [SUM_W-1:0] r_a_rho;
    t_meta                   r_a_meta;
    logic [46:0]             r_b_sqx, r_b_sqy;
    t_val                    r_b_ux, r_b_uy;
    t_val                    r_b_f [NUM_DIR];
    logic signed [SUM_W-1:0] r_b_rho;
    t_meta                   r_b_meta;
    logic [USQ_W-1:0]        r_c_usq3;
    t_val                    r_c_ux, r_c_uy;
    t_val                    r_c_f [NUM_DIR];
    logic signed [SUM_W-1:0] r_c_rho;
    t_meta                   r_c_meta;
    t_meta                   r_m [LANE_DEPTH];
    logic [STAGES-1:0]       r_vld;

    t_val                    in_f [NUM_DIR];
    logic signed [SUM_W-1:0] in_rho;
    logic signed [MOM_W-1:0] in_mx, in_my;
    logic                    in_take;
    logic                    div_load;
    logic                    pipe_en;
    logic                    ser_ready;
    logic                    ser_load;
    t_val                    div_ux, div_uy;
    logic signed [47:0]      sqx, sqy;
    logic [47:0]             sq_sum;
    logic [48:0]             sq3;
    t_val                    lane_post [NUM_DIR];

    assign in_f[0] = i_in_word.dist_rest;
    assign in_f[1] = i_in_word.dist_east;
    assign in_f[2] = i_in_word.dist_north;
    assign in_f[3] = i_in_word.dist_west;
    assign in_f[4] = i_in_word.dist_south;
    assign in_f[5] = i_in_word.dist_northeast;
    assign in_f[6] = i_in_word.dist_northwest;
    assign in_f[7] = i_in_word.dist_southwest;
    assign in_f[8] = i_in_word.dist_southeast;

    assign in_rho = ((SUM_W'(in_f[0]) + SUM_W'(in_f[1])) + (SUM_W'(in_f[2]) + SUM_W'(in_f[3])))
                  + ((SUM_W'(in_f[4]) + SUM_W'(in_f[5])) + (SUM_W'(in_f[6]) + SUM_W'(in_f[7])))
                  + SUM_W'(in_f[8]);
    assign in_mx  = (MOM_W'(in_f[1]) - MOM_W'(in_f[3])) + (MOM_W'(in_f[5]) - MOM_W'(in_f[6]))
                  + (MOM_W'(in_f[8]) - MOM_W'(in_f[7]));
    assign in_my  = (MOM_W'(in_f[2]) - MOM_W'(in_f[4])) + (MOM_W'(in_f[5]) + MOM_W'(in_f[6]))
                  - (MOM_W'(in_f[7]) + MOM_W'(in_f[8]));

    assign pipe_en    = !(r_vld[STAGES-1] && !ser_ready);
    assign ser_load   = r_vld[STAGES-1] && ser_ready;
    assign div_load   = r_s_valid && !r_div_busy && (!r_div_done || pipe_en);
    assign o_in_stall = r_s_valid && !div_load;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega    <= OMEGA_RESET;
            r_s_valid  <= 1'b0;
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_div_cnt  <= '0;
            r_vld      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_omega <= i_cfg_wdata;
            end
            if (in_take) begin
                r_s_valid <= 1'b1;
            end else if (div_load) begin
                r_s_valid <= 1'b0;
            end
            if (div_load) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= '0;
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
            if (pipe_en) begin
                r_vld <= {r_vld[STAGES-2:0], r_div_done};
                if (r_div_done && !(r_div_busy && r_div_cnt == DIV_CNT_W'(DIV_CYCLES - 1))) begin
                    r_div_done <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s_f   <= in_f;
            r_s_x   <= i_in_word.cell_x;
            r_s_y   <= i_in_word.cell_y;
            r_s_rho <= in_rho;
            r_s_mx  <= in_mx;
            r_s_my  <= in_my;
        end
        if (div_load) begin
            r_d_f      <= r_s_f;
            r_d_rho    <= r_s_rho;
            r_d_meta.x <= r_s_x;
            r_d_meta.y <= r_s_y;
            r_d_meta.z <= (r_s_rho == '0);
        end
    end

    lbm_div u_div_x (
        .i_clk   (i_clk),
        .i_start (div_load),
        .i_step  (r_div_busy),
        .i_num   (r_s_mx),
        .i_den   (r_s_rho),
        .o_quot  (div_ux)
    );

    lbm_div u_div_y (
        .i_clk   (i_clk),
        .i_start (div_load),
        .i_step  (r_div_busy),
        .i_num   (r_s_my),
        .i_den   (r_s_rho),
        .o_quot  (div_uy)
    );

    always_comb begin
        sqx    = r_a_ux * r_a_ux;
        sqy    = r_a_uy * r_a_uy;
        sq_sum = {1'b0, r_b_sqx} + {1'b0, r_b_sqy};
        sq3    = {sq_sum, 1'b0} + {1'b0, sq_sum};
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_a_ux   <= div_ux;
            r_a_uy   <= div_uy;
            r_a_f    <= r_d_f;
            r_a_rho  <= r_d_rho;
            r_a_meta <= r_d_meta;
            r_b_sqx  <= sqx[46:0];
            r_b_sqy  <= sqy[46:0];
            r_b_ux   <= r_a_ux;
            r_b_uy   <= r_a_uy;
            r_b_f    <= r_a_f;
            r_b_rho  <= r_a_rho;
            r_b_meta <= r_a_meta;
            r_c_usq3 <= sq3[48:21];
            r_c_ux   <= r_b_ux;
            r_c_uy   <= r_b_uy;
            r_c_f    <= r_b_f;
            r_c_rho  <= r_b_rho;
            r_c_meta <= r_b_meta;
            r_m[0]   <= r_c_meta;
            for (int k = 1; k < LANE_DEPTH; k++) begin
                r_m[k] <= r_m[k-1];
            end
        end
    end

    for (genvar g = 0; g < NUM_DIR; g++) begin : g_lane
        lbm_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (pipe_en),
            .i_dir   (DIR_W'(g)),
            .i_ux    (r_c_ux),
            .i_uy    (r_c_uy),
            .i_usq3  (r_c_usq3),
            .i_rho   (r_c_rho),
            .i_f     (r_c_f[g]),
            .i_omega (r_omega),
            .o_post  (lane_post[g])
        );
    end

    lbm_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ser_load),
        .i_post  (lane_post),
        .i_meta  (r_m[LANE_DEPTH-1]),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .o_ready (ser_ready)
    );

    a_stall_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s_valid)
        else $error("input stalled with an empty slot");

    a_div_busy_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !r_div_done)
        else $error("divider result pending while dividing");

    a_next_cell_starts_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_word.last)
        |=> (!o_out_valid || o_out_word.direction == DIR_REST))
        else $error("cell output did not restart at rest direction");

    a_blocked_cell_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STAGES-1] && !pipe_en) |=> r_vld[STAGES-1])
        else $error("finished cell lost while merge stage was busy");

endmodule

`default_nettype wire

[test/d2q9_bgk_collide_stream_core_test.sv]
// Self-checking testbench of the D2Q9 BGK collide-and-stream core, directed and random cells.
`default_nettype none

module d2q9_bgk_collide_stream_core_test;
    import lbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CELLS = 236;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    t_in_word           i_in_word = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_word          o_out_word;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [OMEGA_W-1:0] i_cfg_wdata = '0;

    d2q9_bgk_collide_stream_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_word(i_in_word), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_word(o_out_word), .i_out_stall(i_out_stall),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    typedef struct {
        t_in_word stim;
        logic     has_known;
        t_val     known_rest;
    } t_cell_row;

    t_out_word   streamed_words[$];
    logic        known_flag[$];
    t_val        known_value[$];
    logic [OMEGA_W-1:0] omega_model;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          words_seen = 0;
    int          cells_sent = 0;
    int          zero_cells = 0;
    bit          stim_done = 1'b0;
    t_cell_row   cell_table[$];

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Predicts the nine streamed words of one cell.
    task automatic predict_collision(input t_in_word c);
        longint f[9];
        longint rho, mx, my, ux, uy, usq3, cu, poly, feq, post, wn, wd;
        t_out_word w;
        f[0] = longint'(c.dist_rest);      f[1] = longint'(c.dist_east);
        f[2] = longint'(c.dist_north);     f[3] = longint'(c.dist_west);
        f[4] = longint'(c.dist_south);     f[5] = longint'(c.dist_northeast);
        f[6] = longint'(c.dist_northwest); f[7] = longint'(c.dist_southwest);
        f[8] = longint'(c.dist_southeast);
        rho = 0; mx = 0; my = 0; ux = 0; uy = 0;
        for (int i = 0; i < NUM_DIR; i++) begin
            rho += f[i];
            mx += f[i] * longint'(DIR_CX[i]);
            my += f[i] * longint'(DIR_CY[i]);
        end
        if (rho != 0) begin
            ux = clip((mx * 64'sd1048576) / rho, -8388608, 8388607);
            uy = clip((my * 64'sd1048576) / rho, -8388608, 8388607);
        end
        usq3 = (3 * (ux * ux + uy * uy)) / 64'sd2097152;
        for (int i = 0; i < NUM_DIR; i++) begin
            cu = 3 * (longint'(DIR_CX[i]) * ux + longint'(DIR_CY[i]) * uy);
            poly = 64'sd1048576 + cu + (cu * cu) / 64'sd2097152 - usq3;
            poly = clip(poly, -(64'sd1 <<< 31), 64'sd1 <<< 31);
            wn = (i == 0) ? 4 : 1;
            wd = (i < 5) ? 9 : 36;
            feq = (rho * poly * wn) / (wd * 64'sd1048576);
            feq = clip(feq, -(64'sd1 <<< 35), 64'sd1 <<< 35);
            post = f[i] - ((f[i] - feq) * longint'({1'b0, omega_model})) / 64'sd1048576;
            post = clip(post, -8388608, 8388607);
            w.dest_x = c.cell_x + COORD_W'(DIR_CX[i]);
            w.dest_y = c.cell_y + COORD_W'(DIR_CY[i]);
            w.direction = DIR_W'(i);
            w.post_value = t_val'(post);
            w.zero_density = (rho == 0);
            w.last = (i == NUM_DIR - 1);
            streamed_words.push_back(w);
        end
    endtask

    function automatic t_in_word random_cell();
        t_in_word c;
        int mode;
        c = '0;
        c.cell_x = COORD_W'($urandom);
        c.cell_y = COORD_W'($urandom);
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            // Physical flows: positive densities near equilibrium.
            c.dist_rest = t_val'($urandom_range(200000, 700000));
            c.dist_east = t_val'($urandom_range(50000, 200000));
            c.dist_north = t_val'($urandom_range(50000, 200000));
            c.dist_west = t_val'($urandom_range(50000, 200000));
            c.dist_south = t_val'($urandom_range(50000, 200000));
            c.dist_northeast = t_val'($urandom_range(10000, 60000));
            c.dist_northwest = t_val'($urandom_range(10000, 60000));
            c.dist_southwest = t_val'($urandom_range(10000, 60000));
            c.dist_southeast = t_val'($urandom_range(10000, 60000));
        end else if (mode < 9) begin
            c.dist_rest = t_val'($urandom);      c.dist_east = t_val'($urandom);
            c.dist_north = t_val'($urandom);     c.dist_west = t_val'($urandom);
            c.dist_south = t_val'($urandom);     c.dist_northeast = t_val'($urandom);
            c.dist_northwest = t_val'($urandom); c.dist_southwest = t_val'($urandom);
            c.dist_southeast = t_val'($urandom);
        end else begin
            // Balanced distributions that sum to zero density.
            c.dist_east = t_val'($urandom);
            c.dist_west = -c.dist_east;
            c.dist_north = t_val'($urandom_range(0, 4000000));
            c.dist_south = -c.dist_north;
            c.dist_northeast = t_val'($urandom_range(0, 4000000));
            c.dist_southwest = -c.dist_northeast;
        end
        return c;
    endfunction

    function automatic t_cell_row make_row(t_in_word c, logic k, t_val r);
        t_cell_row row;
        row.stim = c; row.has_known = k; row.known_rest = r;
        return row;
    endfunction

    function automatic t_in_word flat_cell(logic [5:0] x, logic [5:0] y, t_val v);
        t_in_word c;
        c.cell_x = x; c.cell_y = y;
        c.dist_rest = v; c.dist_east = v; c.dist_north = v; c.dist_west = v;
        c.dist_south = v; c.dist_northeast = v; c.dist_northwest = v;
        c.dist_southwest = v; c.dist_southeast = v;
        return c;
    endfunction

    task automatic send_cell(input t_in_word c, input logic k, input t_val r);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_collision(c);
        for (int i = 0; i < NUM_DIR; i++) begin
            known_flag.push_back(k && i == 0);
            known_value.push_back(r);
        end
        if (c.dist_rest + c.dist_east + c.dist_north + c.dist_west + c.dist_south
            + c.dist_northeast + c.dist_northwest + c.dist_southwest + c.dist_southeast == 0)
            zero_cells++;
        i_in_valid <= 1'b1;
        i_in_word <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        cells_sent++;
    endtask

    task automatic write_omega(input logic [OMEGA_W-1:0] value);
        i_in_valid <= 1'b0;
        while (streamed_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        omega_model = value;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    int out_wait = 0;
    always @(posedge i_clk) begin
        int hold;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_out_word exp_w;
            logic k;
            t_val r;
            words_seen++;
            if (streamed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word %h", o_out_word);
            end else begin
                exp_w = streamed_words.pop_front();
                k = known_flag.pop_front();
                r = known_value.pop_front();
                if (o_out_word !== exp_w || (k && o_out_word.post_value !== r)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h, got %h", exp_w, o_out_word);
                end
            end
        end
        if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            i_out_stall <= 1'b1;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
        end else begin
            hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
            if (hold > 0) begin
                out_wait <= hold - 1;
                i_out_stall <= 1'b1;
            end
        end
    end

    initial begin
        t_in_word c;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        omega_model = OMEGA_RESET;

        // A cell of zero density has a zero equilibrium, so a zero rest value stays zero.
        cell_table.push_back(make_row(flat_cell(6'd0, 6'd0, 24'sd0), 1'b1, 24'sd0));
        cell_table.push_back(make_row(flat_cell(6'd63, 6'd63, 24'sd116508), 1'b0, 24'sd0));
        cell_table.push_back(make_row(flat_cell(6'd0, 6'd63, VAL_MAX), 1'b0, 24'sd0));
        cell_table.push_back(make_row(flat_cell(6'd63, 6'd0, VAL_MIN), 1'b0, 24'sd0));
        cell_table.push_back(make_row(flat_cell(6'd31, 6'd32, -24'sd1), 1'b0, 24'sd0));
        c = flat_cell(6'd5, 6'd9, 24'sd0);
        c.dist_east = VAL_MAX; c.dist_west = -VAL_MAX;
        cell_table.push_back(make_row(c, 1'b1, 24'sd0));
        c = flat_cell(6'd1, 6'd2, 24'sd0);
        c.dist_east = 24'sd1;
        cell_table.push_back(make_row(c, 1'b0, 24'sd0));
        c = flat_cell(6'd40, 6'd17, 24'sd0);
        c.dist_rest = VAL_MAX; c.dist_northeast = VAL_MIN; c.dist_southwest = VAL_MAX;
        cell_table.push_back(make_row(c, 1'b0, 24'sd0));
        c = flat_cell(6'd2, 6'd61, 24'sd0);
        c.dist_north = VAL_MAX; c.dist_south = VAL_MIN + 24'sd1;
        cell_table.push_back(make_row(c, 1'b0, 24'sd0));
        for (int i = 0; i < 6; i++)
            cell_table.push_back(make_row(random_cell(), 1'b0, 24'sd0));

        foreach (cell_table[i])
            send_cell(cell_table[i].stim, cell_table[i].has_known, cell_table[i].known_rest);

        write_omega('0);
        for (int i = 0; i < 4; i++) send_cell(random_cell(), 1'b0, 24'sd0);
        write_omega({OMEGA_W{1'b1}});
        for (int i = 0; i < 4; i++) send_cell(random_cell(), 1'b0, 24'sd0);
        write_omega(22'd2097152);
        for (int i = 0; i < 4; i++) send_cell(random_cell(), 1'b0, 24'sd0);

        for (int phase = 0; phase < 4; phase++) begin
            write_omega(OMEGA_W'($urandom_range(0, 2097152)));
            for (int i = 0; i < RANDOM_CELLS / 4; i++) send_cell(random_cell(), 1'b0, 24'sd0);
        end
        write_omega(OMEGA_RESET);
        for (int i = 0; i < 8; i++) send_cell(random_cell(), 1'b0, 24'sd0);

        i_in_valid <= 1'b0;
        while (streamed_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d cells (%0d of zero density) and checked %0d streamed words.",
                 cells_sent, zero_cells, words_seen);
        $display("Omega covered zero, the 22-bit maximum, 2.0, the default and random values.");
        if (mismatches == 0 && streamed_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
design/lbm_pkg.sv
design/lbm_div.sv
design/lbm_lane.sv
design/lbm_ser.sv
design/d2q9_bgk_collide_stream_core.sv
test/d2q9_bgk_collide_stream_core_test.sv
